FILE: rtl/ogam_pkg.sv
// Shared types, constants and cell update function for the occupancy grid.
`timescale 1ns / 1ps
package ogam_pkg;

  localparam int GridSideMax = 64;
  localparam int GridBits    = $clog2(GridSideMax);
  localparam int SideW       = GridBits + 1;
  localparam int AddrW       = 2 * GridBits;
  localparam int CellsTotal  = GridSideMax * GridSideMax;
  localparam int AgeBits     = 16;
  localparam int StateBits   = 2;
  localparam int CellW       = AgeBits + StateBits;
  localparam int CfgW        = 16;
  localparam int CfgIdxW     = 2;
  localparam int InW         = 56;
  localparam int OutW        = 24;

  localparam logic [AgeBits-1:0] AgeCap = '1;

  // operation codes
  localparam logic [1:0] OpAge   = 2'd0;
  localparam logic [1:0] OpMerge = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  // cell state codes
  localparam logic [StateBits-1:0] StUnknown  = 2'd0;
  localparam logic [StateBits-1:0] StFree     = 2'd1;
  localparam logic [StateBits-1:0] StOccupied = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgGridWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGridHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxAge     = 2'd2;

  typedef struct packed {
    logic [AgeBits-1:0]   age;
    logic [StateBits-1:0] state;
  } cell_t;

  typedef struct packed {
    logic             busy;
    logic             last;
    logic [AddrW-1:0] addr;
  } scan_t;

  // One aging tick of a stored cell.
  function automatic cell_t age_cell(cell_t c, logic [AgeBits-1:0] max_age);
    cell_t                r;
    logic [AgeBits-1:0]   inc;
    r   = c;
    inc = (c.age == AgeCap) ? c.age : c.age + AgeBits'(1);
    if (c.state != StUnknown) begin
      if (inc > max_age) begin
        r.state = StUnknown;
        r.age   = '0;
      end else begin
        r.age = inc;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/occupancy_grid_aging_merge.sv
// Occupancy grid store with cell aging sweep, patch merge and cell read.
// Read and merge: result registered in update; a new item waits for idle.
// Age: every cell in use is aged, then drain, lookup and update give the result.
// The sweep rate is set by the single read port of the cell memory (one cell per cycle).
// Reset: a clearing pass writes all 4096 cells to unknown, age 0, with tready low;
// configuration writes are taken during the pass.
`timescale 1ns / 1ps
module occupancy_grid_aging_merge
  import ogam_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // patch origin x, patch origin y, patch_x, patch_y, observed_state
  input  logic [InW-1:0]     s_axis_tdata,
  // operation
  input  logic [1:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // inside_grid, was_written, stored_state, stored_age, occupied_seen
  output logic [OutW-1:0]    m_axis_tdata,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  state_e state_q, state_d;

  logic [SideW-1:0]   grid_width_q, grid_height_q;
  logic [AgeBits-1:0] max_age_q;
  logic [SideW-1:0]   w_used, h_used;

  // input fields
  logic [1:0]           in_op;
  logic [15:0]          in_off_x, in_off_y;
  logic [7:0]           in_px, in_py;
  logic [StateBits-1:0] in_obs;
  logic [16:0]          gx, gy;
  logic                 in_inside;
  logic [AddrW-1:0]     in_addr;
  logic                 in_fire;

  logic [1:0]           op_q, op_d;
  logic [StateBits-1:0] obs_q, obs_d;
  logic                 inside_q, inside_d;
  logic [AddrW-1:0]     tgt_q, tgt_d;

  logic             pipe_q, pipe_d;
  logic [AddrW-1:0] pipe_addr_q, pipe_addr_d;
  logic             seen_q, seen_d;
  logic             out_valid_q, out_valid_d;
  logic [OutW-1:0]  out_data_q, out_data_d;

  scan_t            scan;
  logic             scan_start;
  logic [SideW-1:0] scan_w, scan_h;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  cell_t            ram_wdata, ram_rdata;

  logic                 out_free;
  logic                 merge_wr;
  logic [StateBits-1:0] res_state;
  logic [AgeBits-1:0]   res_age;

  assign in_op    = s_axis_tuser;
  assign in_off_x = s_axis_tdata[15:0];
  assign in_off_y = s_axis_tdata[31:16];
  assign in_px    = s_axis_tdata[39:32];
  assign in_py    = s_axis_tdata[47:40];
  assign in_obs   = s_axis_tdata[49:48];

  assign w_used = (grid_width_q > SideW'(GridSideMax)) ? SideW'(GridSideMax) : grid_width_q;
  assign h_used = (grid_height_q > SideW'(GridSideMax)) ? SideW'(GridSideMax) : grid_height_q;

  assign gx = {in_off_x[15], in_off_x} + {9'd0, in_px};
  assign gy = {in_off_y[15], in_off_y} + {9'd0, in_py};
  assign in_inside = !gx[16] && (gx < {10'd0, w_used}) && !gy[16] && (gy < {10'd0, h_used});
  assign in_addr   = in_inside ? {gy[GridBits-1:0], gx[GridBits-1:0]} : '0;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign scan_start = in_fire && (in_op == OpAge);
  assign scan_w     = w_used;
  assign scan_h     = h_used;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= SideW'(64);
      grid_height_q <= SideW'(64);
      max_age_q     <= AgeBits'(10);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgGridWidth:  grid_width_q  <= cfg_data_i[SideW-1:0];
        CfgGridHeight: grid_height_q <= cfg_data_i[SideW-1:0];
        CfgMaxAge:     max_age_q     <= cfg_data_i[AgeBits-1:0];
        default: ;
      endcase
    end
  end

  ogam_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .width_i  (scan_w),
    .height_i (scan_h),
    .scan_o   (scan)
  );

  ogam_ram #(
    .Width (CellW),
    .Depth (CellsTotal)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // merge decision on the target cell
  assign merge_wr = (op_q == OpMerge) && inside_q &&
                    ((obs_q == StFree) || (obs_q == StOccupied)) &&
                    !((ram_rdata.state == StOccupied) && (obs_q == StFree));
  assign res_state = !inside_q ? StUnknown : (merge_wr ? obs_q : ram_rdata.state);
  assign res_age   = (!inside_q || merge_wr) ? '0 : ram_rdata.age;

  // memory port selection
  always_comb begin
    ram_raddr = tgt_q;
    ram_we    = 1'b0;
    ram_waddr = pipe_addr_q;
    ram_wdata = age_cell(ram_rdata, max_age_q);
    case (state_q)
      ST_CLEAR: begin
        ram_we    = scan.busy;
        ram_waddr = scan.addr;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_raddr = in_addr;
      end
      ST_SWEEP: begin
        ram_raddr = scan.addr;
        ram_we    = pipe_q;
      end
      ST_DRAIN: begin
        ram_we = pipe_q;
      end
      ST_UPDATE: begin
        ram_we    = out_free && merge_wr;
        ram_waddr = tgt_q;
        ram_wdata = '{age: '0, state: obs_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    obs_d       = obs_q;
    inside_d    = inside_q;
    tgt_d       = tgt_q;
    pipe_d      = 1'b0;
    pipe_addr_d = scan.addr;
    seen_d      = seen_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    case (state_q)
      ST_CLEAR: begin
        if (scan.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          op_d     = in_op;
          obs_d    = in_obs;
          inside_d = in_inside;
          tgt_d    = in_addr;
          state_d  = (in_op == OpAge) ? ST_SWEEP : ST_UPDATE;
        end
      end
      ST_SWEEP: begin
        // read one cell per cycle, write it back aged on the next
        pipe_d = scan.busy;
        if (!scan.busy || scan.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          seen_d      = seen_q || (merge_wr && (obs_q == StOccupied));
          out_valid_d = 1'b1;
          out_data_d  = OutW'({seen_d, res_age, res_state, merge_wr, inside_q});
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pipe_q      <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pipe_q      <= pipe_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    obs_q       <= obs_d;
    inside_q    <= inside_d;
    tgt_q       <= tgt_d;
    pipe_addr_q <= pipe_addr_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/ogam_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ogam_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ogam_scan.sv
// Row/column address generator for the clearing pass and the aging sweep.
`timescale 1ns / 1ps
module ogam_scan
  import ogam_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SideW-1:0] width_i,
  input  logic [SideW-1:0] height_i,
  output scan_t            scan_o
);

  logic                run_q, run_d;
  logic [GridBits-1:0] col_q, col_d;
  logic [GridBits-1:0] row_q, row_d;
  logic [SideW-1:0]    w_q, w_d;
  logic [SideW-1:0]    h_q, h_d;
  logic                col_end, row_end;

  assign col_end = ({1'b0, col_q} == w_q - SideW'(1));
  assign row_end = ({1'b0, row_q} == h_q - SideW'(1));

  always_comb begin
    run_d = run_q;
    col_d = col_q;
    row_d = row_q;
    w_d   = w_q;
    h_d   = h_q;
    if (start_i) begin
      w_d   = width_i;
      h_d   = height_i;
      col_d = '0;
      row_d = '0;
      run_d = (width_i != '0) && (height_i != '0);
    end else if (run_q) begin
      if (col_end) begin
        col_d = '0;
        if (row_end) begin
          run_d = 1'b0;
        end else begin
          row_d = row_q + GridBits'(1);
        end
      end else begin
        col_d = col_q + GridBits'(1);
      end
    end
  end

  // Out of reset, run a full pass over the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b1;
      col_q <= '0;
      row_q <= '0;
      w_q   <= SideW'(GridSideMax);
      h_q   <= SideW'(GridSideMax);
    end else begin
      run_q <= run_d;
      col_q <= col_d;
      row_q <= row_d;
      w_q   <= w_d;
      h_q   <= h_d;
    end
  end

  assign scan_o.busy = run_q;
  assign scan_o.last = run_q && col_end && row_end;
  assign scan_o.addr = {row_q, col_q};

endmodule
